// ----- rtl/core/wnm_pkg.sv -----
package wnm_pkg;

	localparam int MAX_STATES = 64;
	localparam int N_SYM      = MAX_STATES + 1;
	localparam int N_ACT      = MAX_STATES + 2;
	localparam int LEN_W      = $clog2(MAX_STATES + 2);

	localparam logic [7:0] SYM_STAR = 8'h2A;
	localparam logic [7:0] SYM_ANY  = 8'h3F;
	localparam logic [7:0] SYM_NUL  = 8'h00;

	localparam logic [1:0] OP_PAT_BYTE = 2'd0;
	localparam logic [1:0] OP_PAT_END  = 2'd1;
	localparam logic [1:0] OP_TEXT     = 2'd2;
	localparam logic [1:0] OP_WORD_END = 2'd3;

	typedef logic [N_SYM-1:0][7:0] sym_arr_t;

	// Decoded command for the item in the input register, gated by its transfer.
	typedef struct packed {
		logic       pat_byte;
		logic       pat_end;
		logic       text;
		logic       word_end;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic             closed;
		logic             overflow_d;
		logic [LEN_W-1:0] len;
	} store_t;

	typedef struct packed {
		logic matched;
		logic alive_d;
	} match_t;

endpackage

// ----- rtl/core/wnm_if.sv -----
interface wnm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;

	modport source (output valid, output opcode, output data_byte, input ready);
	modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface wnm_out_if;
	logic valid;
	logic ready;
	logic word_done;
	logic matched;
	logic alive;
	logic pattern_overflow;

	modport source (output valid, output word_done, output matched, output alive,
		output pattern_overflow, input ready);
	modport sink (input valid, input word_done, input matched, input alive,
		input pattern_overflow, output ready);
endinterface

// ----- rtl/core/wnm_pattern_store.sv -----
module wnm_pattern_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wnm_pkg::cmd_t             cmd,
	output wnm_pkg::sym_arr_t         sym,
	output logic [wnm_pkg::N_SYM-1:0] star,
	output wnm_pkg::store_t           status
);

	logic [wnm_pkg::LEN_W-1:0] len_q, len_d, base_len;
	logic                      pend_q, pend_d, base_pend;
	logic                      ovf_q, ovf_d, base_ovf;
	logic                      closed_q, closed_d;
	logic                      wr_en;
	logic [7:0]                wr_sym;
	logic                      wr_star;
	logic [wnm_pkg::LEN_W-1:0] wr_idx;
	wnm_pkg::sym_arr_t         sym_q;
	logic [wnm_pkg::N_SYM-1:0] star_q;

	always_comb begin
		// A pattern byte after a closed pattern starts a fresh one.
		base_len  = closed_q ? '0 : len_q;
		base_pend = closed_q ? 1'b0 : pend_q;
		base_ovf  = closed_q ? 1'b0 : ovf_q;
		len_d     = len_q;
		pend_d    = pend_q;
		ovf_d     = ovf_q;
		closed_d  = closed_q;
		wr_en     = 1'b0;
		wr_sym    = cmd.data;
		wr_star   = base_pend;
		wr_idx    = base_len;
		if (cmd.pat_byte) begin
			closed_d = 1'b0;
			len_d    = base_len;
			ovf_d    = base_ovf;
			pend_d   = 1'b0;
			if (!base_pend && cmd.data == wnm_pkg::SYM_STAR) begin
				pend_d = 1'b1;
			end else if (base_len >= wnm_pkg::LEN_W'(wnm_pkg::MAX_STATES)) begin
				ovf_d = 1'b1;
			end else begin
				wr_en = 1'b1;
				len_d = base_len + wnm_pkg::LEN_W'(1);
			end
		end else if (cmd.pat_end && !closed_q) begin
			wr_sym   = wnm_pkg::SYM_NUL;
			wr_star  = pend_q;
			wr_idx   = len_q;
			pend_d   = 1'b0;
			closed_d = 1'b1;
			if (len_q < wnm_pkg::LEN_W'(wnm_pkg::N_SYM)) begin
				wr_en = 1'b1;
				len_d = len_q + wnm_pkg::LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			pend_q   <= 1'b0;
			ovf_q    <= 1'b0;
			closed_q <= 1'b0;
		end else begin
			len_q    <= len_d;
			pend_q   <= pend_d;
			ovf_q    <= ovf_d;
			closed_q <= closed_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			sym_q[wr_idx] <= wr_sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			star_q <= '0;
		end else if (wr_en) begin
			star_q[wr_idx] <= wr_star;
		end
	end

	assign sym               = sym_q;
	assign star              = star_q;
	assign status.closed     = closed_q;
	assign status.overflow_d = ovf_d;
	assign status.len        = len_q;

endmodule

// ----- rtl/core/wnm_active_set.sv -----
module wnm_active_set (
	input  logic                      clk,
	input  logic                      arst_n,
	input  wnm_pkg::cmd_t             cmd,
	input  wnm_pkg::sym_arr_t         sym,
	input  logic [wnm_pkg::N_SYM-1:0] star,
	input  wnm_pkg::store_t           store,
	output logic [wnm_pkg::N_ACT-1:0] active,
	output wnm_pkg::match_t           result
);

	logic [wnm_pkg::N_ACT-1:0] active_q, active_d, nxt;
	logic                      failed_q, failed_d;
	logic [7:0]                feed;
	logic                      any;
	logic                      restart;

	// End of word feeds NUL through the same transition logic as a text byte.
	assign feed = cmd.word_end ? wnm_pkg::SYM_NUL : cmd.data;

	always_comb begin
		nxt = '0;
		for (int i = 0; i < wnm_pkg::N_SYM; i++) begin
			if (active_q[i] && wnm_pkg::LEN_W'(i) < store.len) begin
				if (sym[i] == feed || sym[i] == wnm_pkg::SYM_ANY) begin
					nxt[i+1] = 1'b1;
				end
				if (star[i]) begin
					nxt[i] = 1'b1;
				end
			end
		end
	end

	assign any     = |nxt;
	assign restart = cmd.word_end || (cmd.pat_end && !store.closed);

	always_comb begin
		active_d = active_q;
		failed_d = failed_q;
		if (restart) begin
			active_d = wnm_pkg::N_ACT'(1);
			failed_d = 1'b0;
		end else if (cmd.text && !failed_q) begin
			if (any) begin
				active_d = nxt;
			end else begin
				active_d = '0;
				failed_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= wnm_pkg::N_ACT'(1);
			failed_q <= 1'b0;
		end else begin
			active_q <= active_d;
			failed_q <= failed_d;
		end
	end

	assign active         = active_q;
	assign result.matched = cmd.word_end && !failed_q && nxt[store.len];
	assign result.alive_d = |active_d;

endmodule

// ----- rtl/core/wildcard_nfa_matcher_core.sv -----
// Glob matcher (with '*' and '?') run as a bit-parallel NFA over up to
// wnm_pkg::MAX_STATES pattern states. Every transaction on item gives exactly one
// transaction on result, in order. An item is taken into an input register and
// its result is written into the output register as it leaves the input one;
// one item is accepted in every cycle while result is not stalled, and the
// parallel update of the active-state vector against all stored symbols
// sets that rate. Load a pattern with pattern bytes and close it with end of
// pattern (or a zero byte), then stream text bytes and end each word with end of
// word (or a zero text byte), which reports matched and restarts at state 0.
module wildcard_nfa_matcher_core (
	input logic        clk,
	input logic        arst_n,
	wnm_in_if.sink     item,
	wnm_out_if.source  result
);

	logic                      valid_s1;
	logic [1:0]                opcode_s1;
	logic [7:0]                data_s1;
	logic                      advance;
	logic                      fire;
	logic [1:0]                op_eff;
	wnm_pkg::cmd_t             cmd;
	wnm_pkg::sym_arr_t         sym;
	logic [wnm_pkg::N_SYM-1:0] star;
	wnm_pkg::store_t           store;
	wnm_pkg::match_t           match;
	logic [wnm_pkg::N_ACT-1:0] active;
	logic                      out_valid_q;
	logic                      word_done_q;
	logic                      matched_q;
	logic                      alive_q;
	logic                      overflow_q;

	assign advance    = !out_valid_q || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			opcode_s1 <= item.opcode;
			data_s1   <= item.data_byte;
		end
	end

	// A zero byte stands for the end item of its kind.
	always_comb begin
		op_eff = opcode_s1;
		if (data_s1 == wnm_pkg::SYM_NUL) begin
			case (opcode_s1)
				wnm_pkg::OP_PAT_BYTE: op_eff = wnm_pkg::OP_PAT_END;
				wnm_pkg::OP_TEXT:     op_eff = wnm_pkg::OP_WORD_END;
				default:              op_eff = opcode_s1;
			endcase
		end
		cmd.pat_byte = fire && op_eff == wnm_pkg::OP_PAT_BYTE;
		cmd.pat_end  = fire && op_eff == wnm_pkg::OP_PAT_END;
		cmd.text     = fire && op_eff == wnm_pkg::OP_TEXT;
		cmd.word_end = fire && op_eff == wnm_pkg::OP_WORD_END;
		cmd.data     = data_s1;
	end

	wnm_pattern_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sym    (sym),
		.star   (star),
		.status (store)
	);

	wnm_active_set u_active (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sym    (sym),
		.star   (star),
		.store  (store),
		.active (active),
		.result (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			word_done_q <= cmd.word_end;
			matched_q   <= match.matched;
			alive_q     <= match.alive_d;
			overflow_q  <= store.overflow_d;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.word_done        = word_done_q;
	assign result.matched          = matched_q;
	assign result.alive            = alive_q;
	assign result.pattern_overflow = overflow_q;

	a_match_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && matched_q |-> word_done_q)
		else $error("match reported on a transaction that did not end a word");

	a_restart_after_word: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.word_end |=> active == wnm_pkg::N_ACT'(1))
		else $error("active set not back at state zero after end of word");

	a_done_is_alive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && word_done_q |-> alive_q)
		else $error("end of word left the active set empty");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		store.len <= wnm_pkg::LEN_W'(wnm_pkg::N_SYM))
		else $error("pattern length beyond the state store");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1800;

	typedef struct packed {
		logic word_done;
		logic matched;
		logic alive;
		logic overflow;
	} glob_result_t;

	typedef struct {
		logic [1:0] op;
		logic [7:0] data;
		bit         drain;
	} glob_item_t;

	logic clk;
	logic arst_n;

	wnm_in_if  item_if();
	wnm_out_if result_if();

	wildcard_nfa_matcher_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	// Predicted matcher state, kept in step with every accepted item.
	logic [7:0]                pat_sym [wnm_pkg::N_SYM];
	logic                      pat_star [wnm_pkg::N_SYM];
	logic [wnm_pkg::N_ACT-1:0] act_set = wnm_pkg::N_ACT'(1);
	int                        pat_len = 0;
	logic                      star_pend = 1'b0;
	logic                      word_fail = 1'b0;
	logic                      ovf_flag = 1'b0;
	logic                      pat_closed = 1'b0;

	glob_item_t   pending_items [$];
	glob_result_t expected_results [$];
	logic [7:0]   cur_pat [$];

	int  queued = 0;
	bit  hold_next = 1'b0;
	int  mismatches = 0;
	int  drv_gap = 0;
	int  drv_calm_left = 0;
	bit  drv_calm = 1'b0;
	int  mon_stall = 0;
	int  mon_calm_left = 0;
	bit  mon_calm = 1'b0;
	int  cycles = 0;

	glob_item_t   next_item;
	glob_result_t pred;
	glob_result_t want;
	glob_result_t got;

	initial begin
		for (int i = 0; i < wnm_pkg::N_SYM; i++) begin
			pat_sym[i]  = 8'h00;
			pat_star[i] = 1'b0;
		end
	end

	function automatic logic [wnm_pkg::N_ACT-1:0] nfa_advance(input logic [7:0] s);
		logic [wnm_pkg::N_ACT-1:0] nxt;
		nxt = '0;
		for (int i = 0; i < pat_len && i < wnm_pkg::N_SYM; i++) begin
			if (act_set[i]) begin
				if (pat_sym[i] == s || pat_sym[i] == wnm_pkg::SYM_ANY)
					nxt[i+1] = 1'b1;
				if (pat_star[i])
					nxt[i] = 1'b1;
			end
		end
		return nxt;
	endfunction

	function automatic glob_result_t glob_step(input logic [1:0] op_in, input logic [7:0] b);
		logic [1:0]                op;
		logic [wnm_pkg::N_ACT-1:0] nxt;
		glob_result_t              r;
		op = op_in;
		r  = '0;
		// A zero byte stands in for the matching end item.
		if (op == wnm_pkg::OP_PAT_BYTE && b == wnm_pkg::SYM_NUL)
			op = wnm_pkg::OP_PAT_END;
		if (op == wnm_pkg::OP_TEXT && b == wnm_pkg::SYM_NUL)
			op = wnm_pkg::OP_WORD_END;
		case (op)
			wnm_pkg::OP_PAT_BYTE: begin
				if (pat_closed) begin
					pat_len    = 0;
					star_pend  = 1'b0;
					ovf_flag   = 1'b0;
					pat_closed = 1'b0;
				end
				if (!star_pend && b == wnm_pkg::SYM_STAR) begin
					star_pend = 1'b1;
				end else begin
					if (pat_len >= wnm_pkg::MAX_STATES) begin
						ovf_flag = 1'b1;
					end else begin
						pat_sym[pat_len]  = b;
						pat_star[pat_len] = star_pend;
						pat_len++;
					end
					star_pend = 1'b0;
				end
			end
			wnm_pkg::OP_PAT_END: begin
				if (!pat_closed) begin
					if (pat_len < wnm_pkg::N_SYM) begin
						pat_sym[pat_len]  = wnm_pkg::SYM_NUL;
						pat_star[pat_len] = star_pend;
						pat_len++;
					end
					star_pend  = 1'b0;
					pat_closed = 1'b1;
					act_set    = wnm_pkg::N_ACT'(1);
					word_fail  = 1'b0;
				end
			end
			wnm_pkg::OP_TEXT: begin
				if (!word_fail) begin
					nxt = nfa_advance(b);
					if (nxt != '0) begin
						act_set = nxt;
					end else begin
						act_set   = '0;
						word_fail = 1'b1;
					end
				end
			end
			default: begin
				r.word_done = 1'b1;
				if (!word_fail) begin
					nxt = nfa_advance(wnm_pkg::SYM_NUL);
					if (pat_len < wnm_pkg::N_ACT)
						r.matched = nxt[pat_len];
				end
				act_set   = wnm_pkg::N_ACT'(1);
				word_fail = 1'b0;
			end
		endcase
		r.alive    = |act_set;
		r.overflow = ovf_flag;
		return r;
	endfunction

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_pat_sym();
		case ($urandom_range(0, 9))
			0: return "a";
			1: return "b";
			2: return "c";
			3, 4: return wnm_pkg::SYM_STAR;
			5, 6: return wnm_pkg::SYM_ANY;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_text_sym();
		case ($urandom_range(0, 3))
			0: return "a";
			1: return "b";
			2: return "c";
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	task automatic add_item(input logic [1:0] op, input logic [7:0] b);
		glob_item_t it;
		it.op         = op;
		it.data       = b;
		it.drain      = hold_next;
		hold_next     = 1'b0;
		pending_items = {pending_items, it};
		queued++;
	endtask

	task automatic add_pat(input string s);
		for (int i = 0; i < s.len(); i++)
			add_item(wnm_pkg::OP_PAT_BYTE, s[i]);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_item(wnm_pkg::OP_TEXT, s[i]);
	endtask

	task automatic load_pattern();
		int n;
		cur_pat.delete();
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 8);
		repeat (n)
			cur_pat = {cur_pat, pick_pat_sym()};
		foreach (cur_pat[i])
			add_item(wnm_pkg::OP_PAT_BYTE, cur_pat[i]);
		// Now and then the pattern is left open so that text runs against a partial store.
		case ($urandom_range(0, 19))
			0: ;
			1, 2, 3, 4: add_item(wnm_pkg::OP_PAT_BYTE, wnm_pkg::SYM_NUL);
			default: add_item(wnm_pkg::OP_PAT_END, 8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic add_word(input bit follow);
		logic [7:0] w [$];
		bit         sp;
		if (follow) begin
			// Build text that walks the pattern, filling star states with a few bytes.
			sp = 1'b0;
			foreach (cur_pat[i]) begin
				if (!sp && cur_pat[i] == wnm_pkg::SYM_STAR) begin
					sp = 1'b1;
				end else begin
					if (sp)
						repeat ($urandom_range(0, 3))
							w = {w, pick_text_sym()};
					w = {w, (cur_pat[i] == wnm_pkg::SYM_ANY) ? pick_text_sym() : cur_pat[i]};
					sp = 1'b0;
				end
			end
			if (sp)
				repeat ($urandom_range(0, 3))
					w = {w, pick_text_sym()};
			if (w.size() > 0 && $urandom_range(0, 4) == 0)
				w[$urandom_range(0, w.size() - 1)] = pick_text_sym();
		end else begin
			repeat ($urandom_range(0, 10))
				w = {w, pick_text_sym()};
		end
		foreach (w[i])
			add_item(wnm_pkg::OP_TEXT, w[i]);
		if ($urandom_range(0, 3) == 0)
			add_item(wnm_pkg::OP_TEXT, wnm_pkg::SYM_NUL);
		else
			add_item(wnm_pkg::OP_WORD_END, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Source side: a marked item waits until no result is outstanding, gaps drawn after each acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_if.valid     <= 1'b0;
			item_if.opcode    <= wnm_pkg::OP_PAT_BYTE;
			item_if.data_byte <= 8'h00;
		end else begin
			if (item_if.valid && item_if.ready) begin
				pred             = glob_step(item_if.opcode, item_if.data_byte);
				expected_results = {expected_results, pred};
				if (drv_calm_left == 0) begin
					drv_calm      = ($urandom_range(0, 3) == 0);
					drv_calm_left = $urandom_range(20, 150);
				end
				drv_calm_left--;
				drv_gap = pick_gap(drv_calm);
			end
			if (!item_if.valid || item_if.ready) begin
				if (drv_gap > 0) begin
					drv_gap--;
					item_if.valid <= 1'b0;
				end else if (pending_items.size() > 0 &&
					(!pending_items[0].drain || expected_results.size() == 0)) begin
					next_item = pending_items.pop_front();
					item_if.valid     <= 1'b1;
					item_if.opcode    <= next_item.op;
					item_if.data_byte <= next_item.data;
				end else begin
					item_if.valid <= 1'b0;
				end
			end
		end
	end

	// Sink side: compare each result transaction with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				got = '{result_if.word_done, result_if.matched, result_if.alive,
					result_if.pattern_overflow};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: done=%b matched=%b alive=%b ovf=%b",
							got.word_done, got.matched, got.alive, got.overflow);
				end else begin
					want = expected_results.pop_front();
					if (got.word_done !== want.word_done || got.matched !== want.matched ||
						got.alive !== want.alive || got.overflow !== want.overflow) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %b%b%b%b, got %b%b%b%b",
								want.word_done, want.matched, want.alive,
								want.overflow, got.word_done, got.matched,
								got.alive, got.overflow);
					end
				end
				if (mon_calm_left == 0) begin
					mon_calm      = ($urandom_range(0, 3) == 0);
					mon_calm_left = $urandom_range(20, 150);
				end
				mon_calm_left--;
			end
			if (mon_stall > 0) begin
				mon_stall--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					mon_stall = pick_gap(mon_calm);
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		// Directed part: empty pattern, repeated close, literal star, wildcard, extreme bytes.
		add_item(wnm_pkg::OP_PAT_END, 8'hFF);
		add_item(wnm_pkg::OP_PAT_END, 8'h00);
		add_item(wnm_pkg::OP_WORD_END, 8'hFF);
		add_pat("**?");
		add_item(wnm_pkg::OP_PAT_BYTE, 8'hFF);
		add_item(wnm_pkg::OP_PAT_BYTE, wnm_pkg::SYM_NUL);
		add_text("x*q");
		add_item(wnm_pkg::OP_TEXT, 8'hFF);
		add_item(wnm_pkg::OP_TEXT, wnm_pkg::SYM_NUL);
		// Text against a pattern that has not been closed yet.
		add_pat("ab");
		add_text("a");
		add_item(wnm_pkg::OP_WORD_END, 8'h5A);
		// A word that fails early and stays failed.
		add_item(wnm_pkg::OP_PAT_END, 8'h00);
		add_text("ca");
		add_item(wnm_pkg::OP_WORD_END, 8'h00);
		// A trailing star makes the closing state self-looping.
		add_pat("a*");
		add_item(wnm_pkg::OP_PAT_END, 8'h3C);
		add_text("ab");
		add_item(wnm_pkg::OP_WORD_END, 8'hA5);

		hold_next = 1'b1;
		while (queued < RANDOM_ITEMS + 27) begin
			if (queued % 400 < 10)
				hold_next = 1'b1;
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 6))
					add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				load_pattern();
				repeat ($urandom_range(1, 6))
					add_word($urandom_range(0, 9) < 7);
			end
		end

		@(posedge arst_n);
		while (pending_items.size() > 0 || item_if.valid)
			@(posedge clk);
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- wildcard_nfa_matcher_core.f -----
rtl/core/wnm_pkg.sv
rtl/core/wnm_if.sv
rtl/core/wnm_pattern_store.sv
rtl/core/wnm_active_set.sv
rtl/core/wildcard_nfa_matcher_core.sv
bench/tb.sv
